// ----- rtl/core/c_bnt_pkg.sv -----
// Shared codes for the brace nesting tracker: scanner state codes, region
// codes, character constants and the scan status struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package c_bnt_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int LEVEL_OUT_W     = 16;
	localparam int REPORT_OUT_W    = 17;

	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_OPEN   = 8'h7b;
	localparam logic [7:0] CH_CLOSE  = 8'h7d;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_STAR   = 8'h2a;

	localparam logic [3:0] ST_CODE    = 4'd0;
	localparam logic [3:0] ST_SQ      = 4'd1;
	localparam logic [3:0] ST_SQ_ESC  = 4'd2;
	localparam logic [3:0] ST_SQ_ESCQ = 4'd3;
	localparam logic [3:0] ST_DQ      = 4'd4;
	localparam logic [3:0] ST_DQ_ESC  = 4'd5;
	localparam logic [3:0] ST_DQ_ESCQ = 4'd6;
	localparam logic [3:0] ST_COMM    = 4'd7;
	localparam logic [3:0] ST_STAR    = 4'd8;
	localparam logic [3:0] ST_SLASH   = 4'd9;

	localparam logic [2:0] RG_CODE   = 3'd0;
	localparam logic [2:0] RG_SQUOTE = 3'd1;
	localparam logic [2:0] RG_DQUOTE = 3'd2;
	localparam logic [2:0] RG_COMM   = 3'd3;
	localparam logic [2:0] RG_SLASH  = 3'd4;

	typedef struct packed {
		logic [3:0] next_state;
		logic [2:0] region;
		logic       brace_chk;  // byte is seen in code: check it for braces
	} scan_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/c_bnt_scan.sv -----
// Lexical scanner next-state logic: code, quoted literals, block comments.
// Depends on c_bnt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c_bnt_scan import c_bnt_pkg::*; (
	input  wire logic [3:0] state,
	input  wire logic [7:0] text_byte,
	output scan_status_t    status
);

	logic [3:0] nxt;
	logic       chk;

	always_comb begin
		nxt = ST_CODE;
		chk = 1'b0;
		unique case (state)
			ST_SQ: begin
				if (text_byte == CH_BSLASH) nxt = ST_SQ_ESC;
				else if (text_byte == CH_SQUOTE) nxt = ST_CODE;
				else nxt = ST_SQ;
			end
			ST_SQ_ESC:  nxt = (text_byte == CH_SQUOTE) ? ST_SQ_ESCQ : ST_SQ;
			// after an escaped quote only the closing quote counts
			ST_SQ_ESCQ: nxt = (text_byte == CH_SQUOTE) ? ST_CODE : ST_SQ;
			ST_DQ: begin
				if (text_byte == CH_BSLASH) nxt = ST_DQ_ESC;
				else if (text_byte == CH_DQUOTE) nxt = ST_CODE;
				else nxt = ST_DQ;
			end
			ST_DQ_ESC:  nxt = (text_byte == CH_DQUOTE) ? ST_DQ_ESCQ : ST_DQ;
			ST_DQ_ESCQ: nxt = (text_byte == CH_DQUOTE) ? ST_CODE : ST_DQ;
			ST_COMM:    nxt = (text_byte == CH_STAR) ? ST_STAR : ST_COMM;
			ST_STAR: begin
				if (text_byte == CH_SLASH) nxt = ST_CODE;
				else if (text_byte == CH_STAR) nxt = ST_STAR;
				else nxt = ST_COMM;
			end
			ST_SLASH: begin
				// byte after a lone slash: quotes and slashes go unseen
				if (text_byte == CH_STAR) begin
					nxt = ST_COMM;
				end else begin
					nxt = ST_CODE;
					chk = 1'b1;
				end
			end
			default: begin
				if (text_byte == CH_SQUOTE) nxt = ST_SQ;
				else if (text_byte == CH_DQUOTE) nxt = ST_DQ;
				else if (text_byte == CH_SLASH) nxt = ST_SLASH;
				else begin
					nxt = ST_CODE;
					chk = 1'b1;
				end
			end
		endcase
	end

	logic [2:0] rg;

	always_comb begin
		unique case (nxt)
			ST_SQ, ST_SQ_ESC, ST_SQ_ESCQ: rg = RG_SQUOTE;
			ST_DQ, ST_DQ_ESC, ST_DQ_ESCQ: rg = RG_DQUOTE;
			ST_COMM, ST_STAR:             rg = RG_COMM;
			ST_SLASH:                     rg = RG_SLASH;
			default:                      rg = RG_CODE;
		endcase
	end

	assign status.next_state = nxt;
	assign status.region     = rg;
	assign status.brace_chk  = chk;

endmodule

`default_nettype wire

// ----- rtl/core/c_bnt_count.sv -----
// Brace level and routine counter update, both saturating.
// Depends on c_bnt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c_bnt_count import c_bnt_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic signed [COUNT_WIDTH-1:0] level,
	input  wire logic        [COUNT_WIDTH-1:0] count,
	input  wire logic        [7:0]             text_byte,
	input  wire logic                          brace_chk,
	output logic signed      [COUNT_WIDTH-1:0] level_nxt,
	output logic             [COUNT_WIDTH-1:0] count_nxt,
	output logic                               routine_end
);

	localparam logic signed [COUNT_WIDTH-1:0] LVL_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic signed [COUNT_WIDTH-1:0] LVL_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
	localparam logic        [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
	localparam logic        [COUNT_WIDTH-1:0] ONE     = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

	logic signed [COUNT_WIDTH-1:0] dec;

	assign dec = (level != LVL_MIN) ? level - ONE : level;

	always_comb begin
		level_nxt   = level;
		count_nxt   = count;
		routine_end = 1'b0;
		if (brace_chk && text_byte == CH_OPEN) begin
			if (level != LVL_MAX) level_nxt = level + ONE;
		end else if (brace_chk && text_byte == CH_CLOSE) begin
			level_nxt = dec;
			// a close that lands on zero ends a routine
			if (dec == '0) begin
				routine_end = 1'b1;
				if (count != CNT_MAX) count_nxt = count + ONE;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/c_brace_nesting_tracker.sv -----
// Top level of the brace nesting tracker: input register, scanner and
// counter state, result register. Depends on c_bnt_pkg, c_bnt_scan, c_bnt_count.
//
// Usage:
//   Input channel in_valid / in_stall carries one source character per item
//   (text_byte) and last_byte, which marks the final character of a text.
//   Output channel out_valid / out_stall carries one result per input item:
//   nest_level, region, routine_end, routines_seen, and on the last byte
//   balanced and reported_routines (both zero on other bytes).
//   One item is taken per cycle sustained while the receiver does not stall;
//   the scanner state and both counters update in the single cycle an item
//   moves from the input register to the result register.
//   When the receiver stalls, the result holds and the input register keeps
//   one more item; in_stall rises only while both are full.
//   After a last byte the scanner returns to code and both counters to zero.
//   arst_n clears all valid flags and the scan state at once; no clearing
//   pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module c_brace_nesting_tracker import c_bnt_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [7:0]               text_byte,
	input  wire logic                     last_byte,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [LEVEL_OUT_W-1:0] nest_level,
	output logic [2:0]                    region,
	output logic                          routine_end,
	output logic [LEVEL_OUT_W-1:0]        routines_seen,
	output logic                          balanced,
	output logic signed [REPORT_OUT_W-1:0] reported_routines
);

	localparam int EXT_W = COUNT_WIDTH + REPORT_OUT_W;

	logic                          valid_s1;
	logic [7:0]                    byte_s1;
	logic                          last_s1;
	logic                          adv;

	logic [3:0]                    state_q;
	logic signed [COUNT_WIDTH-1:0] level_q;
	logic [COUNT_WIDTH-1:0]        count_q;

	scan_status_t                  scan;
	logic signed [COUNT_WIDTH-1:0] level_nxt;
	logic [COUNT_WIDTH-1:0]        count_nxt;
	logic                          rend;
	logic signed [EXT_W-1:0]       level_ext;
	logic [EXT_W-1:0]              count_m1;

	assign adv      = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= text_byte;
			last_s1 <= last_byte;
		end
	end

	c_bnt_scan u_scan (
		.state     (state_q),
		.text_byte (byte_s1),
		.status    (scan)
	);

	c_bnt_count #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_count (
		.level       (level_q),
		.count       (count_q),
		.text_byte   (byte_s1),
		.brace_chk   (scan.brace_chk),
		.level_nxt   (level_nxt),
		.count_nxt   (count_nxt),
		.routine_end (rend)
	);

	assign level_ext = EXT_W'(level_nxt);
	assign count_m1  = {{REPORT_OUT_W{1'b0}}, count_nxt} - EXT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CODE;
			level_q   <= '0;
			count_q   <= '0;
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= valid_s1;
			if (valid_s1) begin
				if (last_s1) begin
					state_q <= ST_CODE;
					level_q <= '0;
					count_q <= '0;
				end else begin
					state_q <= scan.next_state;
					level_q <= level_nxt;
					count_q <= count_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			nest_level    <= level_ext[LEVEL_OUT_W-1:0];
			region        <= scan.region;
			routine_end   <= rend;
			routines_seen <= count_m1[LEVEL_OUT_W-1:0] + LEVEL_OUT_W'(1);
			if (last_s1) begin
				balanced          <= (level_nxt == '0);
				reported_routines <= count_m1[REPORT_OUT_W-1:0];
			end else begin
				balanced          <= 1'b0;
				reported_routines <= '0;
			end
		end
	end

	// input side only stalls behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held result");

	a_rend_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && routine_end) |-> (nest_level == '0))
		else $error("routine end with nonzero level");

	a_bal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && balanced) |-> (nest_level == '0))
		else $error("balanced verdict with nonzero level");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(nest_level)
			&& $stable(routines_seen)))
		else $error("stalled result changed");

endmodule

`default_nettype wire
